// ===== rtl/lpc_pkg.sv =====
// Shared types, constants and saturation helpers for the LPC analysis block.
package lpc_pkg;

   localparam int MAX_ORDER_DEF   = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int ACC_W   = 48;
   localparam int COEF_W  = 32;
   localparam int PROD_W  = 56;
   localparam int Q_FRAC  = 27;
   // integer part is below 16, so 4 + Q_FRAC quotient bits
   localparam int DIV_STEPS = Q_FRAC + 4;

   localparam logic [4:0] ORDER_RESET = 5'd8;

   // register indexes on the write port
   localparam logic CSR_ORDER = 1'b0;
   localparam logic CSR_MODE  = 1'b1;

   localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   typedef struct packed {
      logic                     start;
      logic                     raw;   // plain product, no Q27 scaling
      logic signed [ACC_W-1:0]  a;
      logic signed [COEF_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] res;
   } mul_rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [ACC_W-1:0] num;
      logic signed [ACC_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [COEF_W-1:0] k;
   } div_rsp_type;

   function automatic logic signed [PROD_W-1:0] sx48(input logic signed [ACC_W-1:0] v);
      return {{(PROD_W-ACC_W){v[ACC_W-1]}}, v};
   endfunction

   function automatic logic signed [PROD_W-1:0] sx32(input logic signed [COEF_W-1:0] v);
      return {{(PROD_W-COEF_W){v[COEF_W-1]}}, v};
   endfunction

   function automatic logic signed [ACC_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = {{(PROD_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
      lo = {{(PROD_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
      if (v > hi)
         return hi[ACC_W-1:0];
      else if (v < lo)
         return lo[ACC_W-1:0];
      else
         return v[ACC_W-1:0];
   endfunction

   function automatic logic signed [COEF_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      if (v > sx32(COEF_MAX))
         return COEF_MAX;
      else if (v < sx32(COEF_MIN))
         return COEF_MIN;
      else
         return v[COEF_W-1:0];
   endfunction

endpackage

// ===== rtl/lpc_levinson_durbin.sv =====
// LPC analysis top level: autocorrelation accumulation, Levinson-Durbin, coefficient output.
// Usage:
//   req_ channel carries one beat per sample; req_last marks the final sample
//   of a window. req_ready is high only while the block is idle.
//   Each sample updates lags 0..MAX_ORDER through one shared multiplier.
//   After the last sample the recursion runs for the configured order: each
//   stage forms the numerator, runs the 31-step divider (no steps when it
//   saturates or the numerator is zero), updates the symmetric pairs, on odd
//   stages also the middle coefficient, then updates the error, all through
//   the same multiplier and divider.
//   rsp_ channel then gives order beats (predictor or reflection coefficients
//   by output_mode), the last one flagged final; zero energy gives one error beat.
//   One output register sits on rsp_; when the receiver stalls the block holds
//   the result and waits, and takes the next sample once the final beat is loaded.
//   csr_ writes order (index 0) and output_mode (index 1); write only while idle.
//   Synchronous reset: order 8, mode 0, delay line and accumulators cleared.
module lpc_levinson_durbin #(
   parameter int MAX_ORDER   = lpc_pkg::MAX_ORDER_DEF,
   parameter int SAMPLE_BITS = lpc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_coefficient,
   output logic [3:0]             rsp_coef_index,
   output logic                   rsp_final_res,
   output logic                   rsp_error,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [4:0]             csr_wdata
);
   import lpc_pkg::*;

   localparam int CNT_W = $clog2(MAX_ORDER + 1);
   localparam int AW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   typedef enum logic [4:0] {
      S_IDLE, S_MAC_GO, S_MAC_WAIT, S_WIN_END, S_ERR_OUT,
      S_STAGE, S_NUM_GO, S_NUM_WAIT, S_DIV_GO, S_DIV_WAIT,
      S_SYM_LO, S_SYM_HI, S_SYM_W1, S_SYM_W2, S_MID_GO, S_MID_WAIT,
      S_ERR1_GO, S_ERR1_WAIT, S_ERR2_GO, S_ERR2_WAIT, S_EMIT
   } state_type;

   state_type                      state_ff;
   logic [4:0]                     order_ff;
   logic                           mode_ff;

   logic signed [SAMPLE_BITS-1:0]  x_ff;
   logic                           last_ff;
   logic signed [SAMPLE_BITS-1:0]  hist_ff [MAX_ORDER];
   logic signed [ACC_W-1:0]        acc0_ff;
   logic signed [ACC_W-1:0]        acc_ff  [MAX_ORDER];   // lags 1..MAX_ORDER
   logic signed [COEF_W-1:0]       pred_ff [MAX_ORDER];
   logic signed [COEF_W-1:0]       refl_ff [MAX_ORDER];
   logic signed [ACC_W-1:0]        err_ff;
   logic signed [ACC_W-1:0]        num_ff;
   logic signed [ACC_W-1:0]        t_ff;
   logic signed [COEF_W-1:0]       k_ff;
   logic signed [COEF_W-1:0]       low_ff;
   logic signed [COEF_W-1:0]       high_ff;
   logic [CNT_W-1:0]               i_ff;
   logic [CNT_W-1:0]               j_ff;
   logic [CNT_W-1:0]               p_ff;

   logic                           rsp_valid_ff;
   logic [31:0]                    rsp_coefficient_ff;
   logic [3:0]                     rsp_coef_index_ff;
   logic                           rsp_final_res_ff;
   logic                           rsp_error_ff;

   mul_req_type                    mul_req_ff;
   mul_rsp_type                    mul_rsp;
   div_req_type                    div_req_ff;
   div_rsp_type                    div_rsp;

   logic [CNT_W-1:0]               jm1;       // lag index during accumulation
   logic [CNT_W-1:0]               idx_hi;    // i-1-j: mirror coef, also lag i-j entry
   logic [CNT_W-1:0]               idx_mid;
   logic [CNT_W-1:0]               pred_idx;
   logic [CNT_W-1:0]               acc_idx;
   logic [CNT_W-1:0]               p_calc;
   logic signed [COEF_W-1:0]       pred_rd;
   logic signed [COEF_W-1:0]       refl_rd;
   logic signed [ACC_W-1:0]        acc_rd;
   logic signed [SAMPLE_BITS-1:0]  hist_rd;
   logic signed [SAMPLE_BITS-1:0]  mac_b;
   logic signed [ACC_W-1:0]        mul_sat;
   logic                           mul_go;    // launch a multiply this cycle
   logic                           rsp_load;  // output register takes a beat

   lpc_mulq u_mulq (.clock, .reset, .req(mul_req_ff), .rsp(mul_rsp));
   lpc_div  u_div  (.clock, .reset, .req(div_req_ff), .rsp(div_rsp));

   assign jm1     = j_ff - CNT_W'(1);
   assign idx_hi  = i_ff - j_ff - CNT_W'(1);
   assign idx_mid = i_ff >> 1;
   assign mul_sat = sat48(mul_rsp.res);

   assign mul_go   = (state_ff == S_MAC_GO) || (state_ff == S_NUM_GO)
                  || (state_ff == S_SYM_HI) || (state_ff == S_MID_GO)
                  || (state_ff == S_ERR1_GO) || (state_ff == S_ERR2_GO)
                  || ((state_ff == S_SYM_W1) && mul_rsp.done);
   assign rsp_load = ((state_ff == S_EMIT) || (state_ff == S_ERR_OUT))
                  && (!rsp_valid_ff || rsp_ready);

   // single read port per store, address picked by the sequencer step
   always_comb begin
      unique case (state_ff)
         S_SYM_HI: pred_idx = idx_hi;
         S_MID_GO: pred_idx = idx_mid;
         default:  pred_idx = j_ff;
      endcase
      unique case (state_ff)
         S_STAGE:  acc_idx = i_ff;
         S_NUM_GO: acc_idx = idx_hi;
         default:  acc_idx = jm1;
      endcase
   end

   assign pred_rd = pred_ff[pred_idx[AW-1:0]];
   assign refl_rd = refl_ff[j_ff[AW-1:0]];
   assign acc_rd  = acc_ff[acc_idx[AW-1:0]];
   assign hist_rd = hist_ff[jm1[AW-1:0]];
   assign mac_b   = (j_ff == '0) ? x_ff : hist_rd;

   // order 0 acts as 1, anything above MAX_ORDER as MAX_ORDER
   always_comb begin
      if (order_ff == '0)
         p_calc = CNT_W'(1);
      else if (6'(order_ff) > 6'(MAX_ORDER))
         p_calc = CNT_W'(MAX_ORDER);
      else
         p_calc = CNT_W'(order_ff);
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coefficient_ff;
   assign rsp_coef_index  = rsp_coef_index_ff;
   assign rsp_final_res   = rsp_final_res_ff;
   assign rsp_error       = rsp_error_ff;

   always_ff @(posedge clock) begin
      mul_req_ff.start <= !reset && mul_go;
      div_req_ff.start <= !reset && (state_ff == S_DIV_GO);
      if (reset) begin
         state_ff     <= S_IDLE;
         order_ff     <= ORDER_RESET;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc0_ff      <= '0;
         err_ff       <= '0;
         for (int n = 0; n < MAX_ORDER; n++) begin
            hist_ff[n] <= '0;
            acc_ff[n]  <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ORDER: order_ff <= csr_wdata;
               CSR_MODE:  mode_ff  <= csr_wdata[0];
               default:   ;
            endcase
         end
         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  x_ff     <= req_sample;
                  last_ff  <= req_last;
                  j_ff     <= '0;
                  state_ff <= S_MAC_GO;
               end
            end
            // lag j: acc[j] += x * x[n-j]
            S_MAC_GO: begin
               mul_req_ff.raw   <= 1'b1;
               mul_req_ff.a     <= ACC_W'(x_ff);
               mul_req_ff.b     <= COEF_W'(mac_b);
               state_ff         <= S_MAC_WAIT;
            end
            S_MAC_WAIT: begin
               if (mul_rsp.done) begin
                  if (j_ff == '0)
                     acc0_ff <= sat48(sx48(acc0_ff) + mul_rsp.res);
                  else
                     acc_ff[jm1[AW-1:0]] <= sat48(sx48(acc_rd) + mul_rsp.res);
                  if (j_ff == CNT_W'(MAX_ORDER)) begin
                     state_ff <= S_WIN_END;
                  end else begin
                     j_ff     <= j_ff + CNT_W'(1);
                     state_ff <= S_MAC_GO;
                  end
               end
            end
            S_WIN_END: begin
               if (last_ff && acc0_ff == '0) begin
                  for (int n = 0; n < MAX_ORDER; n++) begin
                     hist_ff[n] <= '0;
                     acc_ff[n]  <= '0;
                  end
               end else begin
                  for (int n = MAX_ORDER - 1; n > 0; n--)
                     hist_ff[n] <= hist_ff[n-1];
                  hist_ff[0] <= x_ff;
               end
               priority if (!last_ff) begin
                  state_ff <= S_IDLE;
               end else if (acc0_ff == '0) begin
                  // zero energy: one error beat, window state cleared
                  err_ff   <= '0;
                  acc0_ff  <= '0;
                  state_ff <= S_ERR_OUT;
               end else begin
                  p_ff     <= p_calc;
                  i_ff     <= '0;
                  err_ff   <= acc0_ff;
                  state_ff <= S_STAGE;
               end
            end
            S_ERR_OUT: begin
               if (rsp_load) begin
                  rsp_coefficient_ff <= '0;
                  rsp_coef_index_ff  <= '0;
                  rsp_final_res_ff   <= 1'b1;
                  rsp_error_ff       <= 1'b1;
                  state_ff           <= S_IDLE;
               end
            end
            // num = -R[i+1] - sum a[j]*R[i-j]
            S_STAGE: begin
               num_ff   <= sat48(-sx48(acc_rd));
               j_ff     <= '0;
               state_ff <= (i_ff == '0) ? S_DIV_GO : S_NUM_GO;
            end
            S_NUM_GO: begin
               mul_req_ff.raw   <= 1'b0;
               mul_req_ff.a     <= acc_rd;
               mul_req_ff.b     <= pred_rd;
               state_ff         <= S_NUM_WAIT;
            end
            S_NUM_WAIT: begin
               if (mul_rsp.done) begin
                  num_ff <= sat48(sx48(num_ff) - mul_rsp.res);
                  if (j_ff + CNT_W'(1) == i_ff) begin
                     state_ff <= S_DIV_GO;
                  end else begin
                     j_ff     <= j_ff + CNT_W'(1);
                     state_ff <= S_NUM_GO;
                  end
               end
            end
            S_DIV_GO: begin
               div_req_ff.num   <= num_ff;
               div_req_ff.den   <= err_ff;
               state_ff         <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_rsp.done) begin
                  k_ff                 <= div_rsp.k;
                  refl_ff[i_ff[AW-1:0]] <= div_rsp.k;
                  pred_ff[i_ff[AW-1:0]] <= div_rsp.k;
                  j_ff                 <= '0;
                  priority if (idx_mid != '0)
                     state_ff <= S_SYM_LO;
                  else if (i_ff[0])
                     state_ff <= S_MID_GO;
                  else
                     state_ff <= S_ERR1_GO;
               end
            end
            // symmetric pair a[j], a[i-1-j], both updated from old values
            S_SYM_LO: begin
               low_ff   <= pred_rd;
               state_ff <= S_SYM_HI;
            end
            S_SYM_HI: begin
               high_ff          <= pred_rd;
               mul_req_ff.raw   <= 1'b0;
               mul_req_ff.a     <= ACC_W'(pred_rd);
               mul_req_ff.b     <= k_ff;
               state_ff         <= S_SYM_W1;
            end
            S_SYM_W1: begin
               if (mul_rsp.done) begin
                  pred_ff[j_ff[AW-1:0]] <= sat32(sx32(low_ff) + mul_rsp.res);
                  mul_req_ff.raw        <= 1'b0;
                  mul_req_ff.a          <= ACC_W'(low_ff);
                  mul_req_ff.b          <= k_ff;
                  state_ff              <= S_SYM_W2;
               end
            end
            S_SYM_W2: begin
               if (mul_rsp.done) begin
                  pred_ff[idx_hi[AW-1:0]] <= sat32(sx32(high_ff) + mul_rsp.res);
                  priority if (j_ff + CNT_W'(1) != idx_mid) begin
                     j_ff     <= j_ff + CNT_W'(1);
                     state_ff <= S_SYM_LO;
                  end else if (i_ff[0]) begin
                     state_ff <= S_MID_GO;
                  end else begin
                     state_ff <= S_ERR1_GO;
                  end
               end
            end
            // odd stage: middle coefficient pairs with itself
            S_MID_GO: begin
               low_ff           <= pred_rd;
               mul_req_ff.raw   <= 1'b0;
               mul_req_ff.a     <= ACC_W'(pred_rd);
               mul_req_ff.b     <= k_ff;
               state_ff         <= S_MID_WAIT;
            end
            S_MID_WAIT: begin
               if (mul_rsp.done) begin
                  pred_ff[idx_mid[AW-1:0]] <= sat32(sx32(low_ff) + mul_rsp.res);
                  state_ff                 <= S_ERR1_GO;
               end
            end
            // err -= (err*k)*k
            S_ERR1_GO: begin
               mul_req_ff.raw   <= 1'b0;
               mul_req_ff.a     <= err_ff;
               mul_req_ff.b     <= k_ff;
               state_ff         <= S_ERR1_WAIT;
            end
            S_ERR1_WAIT: begin
               if (mul_rsp.done) begin
                  t_ff     <= mul_sat;
                  state_ff <= S_ERR2_GO;
               end
            end
            S_ERR2_GO: begin
               mul_req_ff.raw   <= 1'b0;
               mul_req_ff.a     <= t_ff;
               mul_req_ff.b     <= k_ff;
               state_ff         <= S_ERR2_WAIT;
            end
            S_ERR2_WAIT: begin
               if (mul_rsp.done) begin
                  err_ff <= sat48(sx48(err_ff) - sx48(mul_sat));
                  if (i_ff + CNT_W'(1) == p_ff) begin
                     acc0_ff <= '0;
                     for (int n = 0; n < MAX_ORDER; n++) begin
                        hist_ff[n] <= '0;
                        acc_ff[n]  <= '0;
                     end
                     j_ff     <= '0;
                     state_ff <= S_EMIT;
                  end else begin
                     i_ff     <= i_ff + CNT_W'(1);
                     state_ff <= S_STAGE;
                  end
               end
            end
            S_EMIT: begin
               if (rsp_load) begin
                  rsp_coefficient_ff <= mode_ff ? refl_rd : pred_rd;
                  rsp_coef_index_ff  <= 4'(j_ff);
                  rsp_final_res_ff   <= (j_ff + CNT_W'(1) == p_ff);
                  rsp_error_ff       <= 1'b0;
                  if (j_ff + CNT_W'(1) == p_ff)
                     state_ff <= S_IDLE;
                  else
                     j_ff <= j_ff + CNT_W'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/lpc_mulq.sv =====
// Shared 24x32 multiplier: plain signed product or 48x32 Q27 product in two halves.
module lpc_mulq (
   input  logic               clock,
   input  logic               reset,
   input  lpc_pkg::mul_req_type req,
   output lpc_pkg::mul_rsp_type rsp
);
   import lpc_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_HI, M_LO, M_OUT} mstate_type;

   mstate_type         state_ff;
   logic [ACC_W-1:0]   ua_ff;
   logic [COEF_W-1:0]  ub_ff;
   logic               neg_ff;
   logic               raw_ff;
   logic [PROD_W-1:0]  hi_ff;
   logic [PROD_W-1:0]  lo_ff;
   mul_rsp_type        rsp_ff;

   logic [23:0]        op_a;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  mag_in;
   logic [PROD_W-1:0]  frac_sum;

   assign op_a     = (state_ff == M_HI) ? ua_ff[ACC_W-1:24] : ua_ff[23:0];
   assign prod     = op_a * ub_ff;
   assign frac_sum = {hi_ff[2:0], 24'b0} + lo_ff;
   assign mag_in   = raw_ff ? lo_ff : ((hi_ff >> 3) + (frac_sum >> Q_FRAC));
   assign rsp      = rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff.done <= !reset && (state_ff == M_OUT);
      if (reset) begin
         state_ff <= M_IDLE;
      end else begin
         unique case (state_ff)
            M_IDLE: begin
               if (req.start) begin
                  ua_ff    <= req.a[ACC_W-1] ? ACC_W'(-req.a) : req.a;
                  ub_ff    <= req.b[COEF_W-1] ? COEF_W'(-req.b) : req.b;
                  neg_ff   <= req.a[ACC_W-1] ^ req.b[COEF_W-1];
                  raw_ff   <= req.raw;
                  state_ff <= req.raw ? M_LO : M_HI;
               end
            end
            M_HI: begin
               hi_ff    <= prod;
               state_ff <= M_LO;
            end
            M_LO: begin
               lo_ff    <= prod;
               state_ff <= M_OUT;
            end
            M_OUT: begin
               rsp_ff.res  <= neg_ff ? -$signed(mag_in) : $signed(mag_in);
               state_ff    <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/lpc_div.sv =====
// Restoring divider: Q4.27 quotient of two 48-bit values, one bit a cycle, saturating.
module lpc_div (
   input  logic               clock,
   input  logic               reset,
   input  lpc_pkg::div_req_type req,
   output lpc_pkg::div_rsp_type rsp
);
   import lpc_pkg::*;

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type          state_ff;
   logic [ACC_W-1:0]    rem_ff;
   logic [ACC_W-1:0]    ad_ff;
   logic [3:0]          sh_ff;
   logic [COEF_W-2:0]   q_ff;
   logic [4:0]          cnt_ff;
   logic                neg_ff;
   div_rsp_type         rsp_ff;

   logic [ACC_W-1:0]    an;
   logic [ACC_W-1:0]    ad;
   logic [ACC_W:0]      trial;
   logic                fits;
   logic [ACC_W-1:0]    rem_in;
   logic [COEF_W-2:0]   q_in;
   logic                quick;     // answer known without iterating

   assign an    = req.num[ACC_W-1] ? ACC_W'(-req.num) : req.num;
   assign ad    = req.den[ACC_W-1] ? ACC_W'(-req.den) : req.den;
   assign trial = {rem_ff, sh_ff[3]};
   assign fits  = trial >= {1'b0, ad_ff};
   assign rem_in = fits ? ACC_W'(trial - {1'b0, ad_ff}) : trial[ACC_W-1:0];
   assign q_in   = {q_ff[COEF_W-3:0], fits};
   assign quick  = (an == '0) || (ad == '0) || ({4'b0, an} >= {ad, 4'b0});
   assign rsp    = rsp_ff;

   always_ff @(posedge clock) begin
      rsp_ff.done <= !reset
                     && (((state_ff == D_IDLE) && req.start && quick)
                         || ((state_ff == D_RUN) && (cnt_ff == 5'(DIV_STEPS - 1))));
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         unique case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  priority if (an == '0) begin
                     rsp_ff.k    <= '0;
                  end else if (ad == '0) begin
                     rsp_ff.k    <= req.num[ACC_W-1] ? COEF_MIN : COEF_MAX;
                  end else if ({4'b0, an} >= {ad, 4'b0}) begin
                     rsp_ff.k    <= (req.num[ACC_W-1] ^ req.den[ACC_W-1]) ? COEF_MIN
                                                                          : COEF_MAX;
                  end else begin
                     rem_ff   <= an >> 4;
                     sh_ff    <= an[3:0];
                     ad_ff    <= ad;
                     q_ff     <= '0;
                     cnt_ff   <= '0;
                     neg_ff   <= req.num[ACC_W-1] ^ req.den[ACC_W-1];
                     state_ff <= D_RUN;
                  end
               end
            end
            D_RUN: begin
               rem_ff <= rem_in;
               sh_ff  <= {sh_ff[2:0], 1'b0};
               q_ff   <= q_in;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(DIV_STEPS - 1)) begin
                  rsp_ff.k    <= neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
                  state_ff    <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/lpc_chk.sv =====
// Port-level checker for the LPC analysis block, bound to the top level.
module lpc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_coefficient,
   input logic [3:0]  rsp_coef_index,
   input logic        rsp_final_res,
   input logic        rsp_error
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coefficient)
         && $stable(rsp_coef_index) && $stable(rsp_final_res) && $stable(rsp_error))
      else $error("result beat changed while stalled");

   // error beat is the only beat of its window
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_final_res && rsp_coefficient == '0
         && rsp_coef_index == '0)
      else $error("malformed error beat");

   // one sample at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after an accepted sample");

   // no new sample while coefficients of a window are still coming
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_res && !rsp_error |-> !req_ready)
      else $error("ready before the final beat was loaded");

endmodule

bind lpc_levinson_durbin lpc_chk u_lpc_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_coefficient, .rsp_coef_index, .rsp_final_res, .rsp_error
);
